### rtl/core/ccsu_pkg.sv
// ----------------------------------------------------------------------------
// ccsu_pkg
// Types and constants shared by the eight-opcode CPU subset core.
// ----------------------------------------------------------------------------
`default_nettype none

package ccsu_pkg;

  // One-hot timing steps.
  localparam logic [6:0] STEP_T1 = 7'h01;
  localparam logic [6:0] STEP_T2 = 7'h02;
  localparam logic [6:0] STEP_T3 = 7'h04;
  localparam logic [6:0] STEP_T4 = 7'h08;
  localparam logic [6:0] STEP_T5 = 7'h10;

  // Implemented opcodes.
  localparam logic [7:0] OP_PLP     = 8'h28;
  localparam logic [7:0] OP_PHA     = 8'h48;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;
  localparam logic [7:0] OP_TXS     = 8'h9A;
  localparam logic [7:0] OP_LDY_IMM = 8'hA0;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;

  // The stack lives in page one.
  localparam logic [7:0] STACK_HIGH = 8'h01;

  // Request codes.
  localparam logic REQ_BUS   = 1'b0;
  localparam logic REQ_RESET = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  read_data;
    logic [15:0] reset_vector;
  } req_t;

  typedef struct packed {
    logic [15:0] bus_address;
    logic [7:0]  bus_write_data;
    logic        bus_read;
    logic [15:0] program_counter;
    logic [7:0]  accumulator;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  stack_pointer;
    logic [7:0]  status_flags;
    logic [7:0]  opcode_held;
    logic        halted;
  } rsp_t;

  // Architectural and sequencing state of the core.
  typedef struct packed {
    logic [6:0]  step;
    logic [7:0]  opcode;
    logic [15:0] pc;
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  flags;
    logic [7:0]  op_lo;
    logic [7:0]  op_hi;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        rd;
    logic        halt;
  } cpu_state_t;

  localparam cpu_state_t STATE_RESET = '{
    step: STEP_T1, opcode: 8'h00, pc: 16'h0000, acc: 8'h00, x: 8'h00,
    y: 8'h00, sp: 8'h00, flags: 8'h00, op_lo: 8'h00, op_hi: 8'h00,
    addr: 16'h0000, data: 8'h00, rd: 1'b1, halt: 1'b0
  };

  function automatic logic is_known(input logic [7:0] op);
    logic known;
    case (op) inside
      OP_PLP, OP_PHA, OP_STA_ABS, OP_TXS,
      OP_LDY_IMM, OP_LDX_IMM, OP_LDA_IMM, OP_LDA_ABS: known = 1'b1;
      default: known = 1'b0;
    endcase
    return known;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ccsu_stream_if.sv
// ----------------------------------------------------------------------------
// ccsu_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccsu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/cycle_accurate_cpu_subset_unit.sv
// ----------------------------------------------------------------------------
// cycle_accurate_cpu_subset_unit
// Bus-cycle-stepped 8-bit CPU core for an eight-opcode subset.
// ----------------------------------------------------------------------------
// The result beat for a request is registered and appears in the cycle after acceptance.
// Throughput: one request per clock while the result consumer keeps up;
// the state update is a single pass through the next-state logic into the state register.
// Reset (rst, synchronous): state returns to its reset values, the output
// register empties, and the core starts with a fetch from address zero.
`default_nettype none

module cycle_accurate_cpu_subset_unit (
  input  wire logic     clk,
  input  wire logic     rst,
  ccsu_stream_if.sink   req,
  ccsu_stream_if.source rsp
);

  // The architectural state and the sequencing step are held here; each
  // accepted request is one bus cycle of the processor.
  ccsu_pkg::cpu_state_t state;
  ccsu_pkg::cpu_state_t state_next;
  ccsu_pkg::rsp_t       rsp_data;
  logic                 rsp_valid;
  logic                 accept;

  // A request is taken whenever the output register is empty or is being
  // drained in the same cycle, so the core never stalls while its result
  // consumer keeps up.
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  ccsu_exec u_exec (
    .cur (state),
    .req (req.payload),
    .nxt (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccsu_pkg::STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Output register: a snapshot of the state after the cycle just run.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data.bus_address     <= state_next.addr;
      rsp_data.bus_write_data  <= state_next.data;
      rsp_data.bus_read        <= state_next.rd;
      rsp_data.program_counter <= state_next.pc;
      rsp_data.accumulator     <= state_next.acc;
      rsp_data.index_x         <= state_next.x;
      rsp_data.index_y         <= state_next.y;
      rsp_data.stack_pointer   <= state_next.sp;
      rsp_data.status_flags    <= state_next.flags;
      rsp_data.opcode_held     <= state_next.opcode;
      rsp_data.halted          <= state_next.halt;
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

endmodule

`default_nettype wire

### rtl/core/ccsu_exec.sv
// ----------------------------------------------------------------------------
// ccsu_exec
// Next-state logic: advances the core by one bus cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ccsu_exec (
  input  wire ccsu_pkg::cpu_state_t cur,
  input  wire ccsu_pkg::req_t       req,
  output ccsu_pkg::cpu_state_t      nxt
);

  logic [7:0]  d;
  logic [15:0] pc_inc;
  logic [6:0]  step_inc;

  assign d        = cur.rd ? req.read_data : cur.data;
  assign pc_inc   = cur.pc + 16'd1;
  assign step_inc = {cur.step[5:0], 1'b0};

  always_comb begin
    nxt = cur;
    if (req.req_type == ccsu_pkg::REQ_RESET) begin
      nxt      = ccsu_pkg::STATE_RESET;
      nxt.pc   = req.reset_vector;
      nxt.addr = req.reset_vector;
    end else if (!cur.halt) begin
      if (cur.step != ccsu_pkg::STEP_T1 && !ccsu_pkg::is_known(cur.opcode)) begin
        nxt.halt = 1'b1;
      end else begin
        nxt.data = d;
        if (cur.step == ccsu_pkg::STEP_T1) begin
          // Opcode fetch completes; read the byte after it.
          nxt.opcode = d;
          nxt.pc     = pc_inc;
          nxt.addr   = pc_inc;
          nxt.rd     = 1'b1;
          nxt.step   = step_inc;
        end else begin
          // Default ending is a fresh fetch from the current PC.
          nxt.addr = cur.pc;
          nxt.rd   = 1'b1;
          nxt.step = ccsu_pkg::STEP_T1;
          unique case (cur.opcode) inside
            ccsu_pkg::OP_PLP: begin
              if (cur.step == ccsu_pkg::STEP_T2) begin
                nxt.addr = cur.addr;
                nxt.rd   = cur.rd;
                nxt.step = step_inc;
              end else if (cur.step == ccsu_pkg::STEP_T3) begin
                nxt.op_lo = cur.sp;
                nxt.op_hi = ccsu_pkg::STACK_HIGH;
                nxt.addr  = {ccsu_pkg::STACK_HIGH, cur.sp};
                nxt.sp    = cur.sp + 8'd1;
                nxt.step  = step_inc;
              end else if (cur.step == ccsu_pkg::STEP_T4) begin
                nxt.op_lo = cur.sp;
                nxt.addr  = {cur.op_hi, cur.sp};
                nxt.step  = step_inc;
              end else if (cur.step == ccsu_pkg::STEP_T5) begin
                nxt.flags = d;
              end
            end
            ccsu_pkg::OP_PHA: begin
              if (cur.step == ccsu_pkg::STEP_T2) begin
                nxt.addr = cur.addr;
                nxt.rd   = cur.rd;
                nxt.step = step_inc;
              end else if (cur.step == ccsu_pkg::STEP_T3) begin
                // Push: write A at the current slot, then move S down.
                nxt.addr = {ccsu_pkg::STACK_HIGH, cur.sp};
                nxt.data = cur.acc;
                nxt.rd   = 1'b0;
                nxt.sp   = cur.sp - 8'd1;
                nxt.step = step_inc;
              end
            end
            ccsu_pkg::OP_LDA_ABS, ccsu_pkg::OP_STA_ABS: begin
              if (cur.step == ccsu_pkg::STEP_T2) begin
                nxt.op_lo = d;
                nxt.pc    = pc_inc;
                nxt.addr  = pc_inc;
                nxt.step  = step_inc;
              end else if (cur.step == ccsu_pkg::STEP_T3) begin
                nxt.op_hi = d;
                nxt.pc    = pc_inc;
                nxt.addr  = {d, cur.op_lo};
                nxt.step  = step_inc;
                if (cur.opcode == ccsu_pkg::OP_STA_ABS) begin
                  nxt.data = cur.acc;
                  nxt.rd   = 1'b0;
                end
              end else if (cur.step == ccsu_pkg::STEP_T4 &&
                           cur.opcode == ccsu_pkg::OP_LDA_ABS) begin
                nxt.acc = d;
              end
            end
            ccsu_pkg::OP_TXS: begin
              nxt.sp = cur.x;
            end
            ccsu_pkg::OP_LDY_IMM: begin
              nxt.y    = d;
              nxt.pc   = pc_inc;
              nxt.addr = pc_inc;
            end
            ccsu_pkg::OP_LDX_IMM: begin
              nxt.x    = d;
              nxt.pc   = pc_inc;
              nxt.addr = pc_inc;
            end
            default: begin
              // Immediate LDA, the only opcode left once the unknown ones halt.
              nxt.acc  = d;
              nxt.pc   = pc_inc;
              nxt.addr = pc_inc;
            end
          endcase
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/ccsu_checker.sv
// ----------------------------------------------------------------------------
// ccsu_checker
// Port-level checks for the CPU subset core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ccsu_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire ccsu_pkg::req_t req_payload,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire ccsu_pkg::rsp_t rsp_payload
);

  // Every accepted request yields a result beat on the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("no result beat after an accepted request");

  // A reset request starts a fetch from the supplied vector, not halted.
  a_reset_fetch: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_payload.req_type == ccsu_pkg::REQ_RESET |=>
      rsp_payload.program_counter == $past(req_payload.reset_vector) &&
      rsp_payload.bus_address == $past(req_payload.reset_vector) &&
      rsp_payload.bus_read && !rsp_payload.halted)
    else $error("reset request did not start a fetch from the vector");

  // A stalled result beat holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("result beat changed while stalled");

endmodule

bind cycle_accurate_cpu_subset_unit ccsu_checker u_ccsu_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_payload (req.payload),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

`default_nettype wire
